[sv/rbvs_pkg.sv]
package rbvs_pkg;

    typedef logic signed [31:0] q16_t;

    localparam int unsigned RegCount = 7;

    localparam logic [2:0] REG_MASS           = 3'd0;
    localparam logic [2:0] REG_FRICTION       = 3'd1;
    localparam logic [2:0] REG_FRICTION_SCALE = 3'd2;
    localparam logic [2:0] REG_VELOCITY_LIMIT = 3'd3;
    localparam logic [2:0] REG_FALL_LIMIT     = 3'd4;
    localparam logic [2:0] REG_GRAVITY_ENABLE = 3'd5;
    localparam logic [2:0] REG_GRAVITY_ACCEL  = 3'd6;

    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_SET  = 1'b1;

    localparam logic signed [41:0] SatMax = 42'sd2147483647;
    localparam logic signed [41:0] SatMin = -42'sd2147483648;

    function automatic logic [31:0] mag32(input q16_t v);
        logic [31:0] r;
        r = v[31] ? (32'd0 - 32'(v)) : 32'(v);
        return r;
    endfunction

    function automatic q16_t sat_add(input q16_t v, input logic neg, input logic [39:0] m);
        logic signed [41:0] s;
        logic signed [41:0] d;
        d = $signed({2'b00, m});
        s = neg ? (42'(v) - d) : (42'(v) + d);
        if (s > SatMax)
        begin
            return q16_t'(SatMax[31:0]);
        end
        else if (s < SatMin)
        begin
            return q16_t'(SatMin[31:0]);
        end
        return q16_t'(s[31:0]);
    endfunction

endpackage

[sv/rbvs_if.sv]
interface rbvs_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [15:0] frame_time;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic        on_ground;

    modport source (output valid, action, force_x, force_y, frame_time, position_x,
                    position_y, on_ground, input ready);
    modport sink (input valid, action, force_x, force_y, frame_time, position_x,
                  position_y, on_ground, output ready);
endinterface

interface rbvs_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;

    modport source (output valid, new_x, new_y, velocity_x, velocity_y, input ready);
    modport sink (input valid, new_x, new_y, velocity_x, velocity_y, output ready);
endinterface

[sv/rigid_body_velocity_step_top.sv]
// One 2D body, Euler step in signed Q16.16. A tick with the body airborne under gravity
// adds force and gravity, clamps each axis and moves the body; when friction meets a zero
// velocity it skips the friction length. Each vector length uses a bit-pair square root;
// each friction or limit scaling divides once per axis with a restoring divider. With gravity
// off, a tick can need the friction length, two scalings, the limit length and two more
// scalings. A set-grounded transaction goes from idle straight to the output state. The
// block holds ready low while it works, and waits in the output state while an earlier
// result is not taken. One shared 32x32 multiplier forms the products; the square root and
// the divider share their iteration registers.
module rigid_body_velocity_step_top (
    input  logic        clk,
    input  logic        rst_n,
    rbvs_in_if.sink     item,
    rbvs_out_if.source  result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rbvs_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0,  S_MD   = 5'd1,  S_FX   = 5'd2,  S_FY   = 5'd3;
    localparam logic [4:0] S_FSEL = 5'd4,  S_FR1  = 5'd5,  S_FR2  = 5'd6,  S_FR3  = 5'd7;
    localparam logic [4:0] S_FR4  = 5'd8,  S_FR5  = 5'd9,  S_SQX  = 5'd10, S_SQY  = 5'd11;
    localparam logic [4:0] S_SQS  = 5'd12, S_SQRT = 5'd13, S_LEN  = 5'd14, S_SCM  = 5'd15;
    localparam logic [4:0] S_SCD  = 5'd16, S_DIV  = 5'd17, S_SCW  = 5'd18, S_GR1  = 5'd19;
    localparam logic [4:0] S_GR2  = 5'd20, S_LIM  = 5'd21, S_PX   = 5'd22, S_PY   = 5'd23;
    localparam logic [4:0] S_PD   = 5'd24, S_FIN  = 5'd25;

    logic [15:0] mass_reg;
    logic [23:0] friction_reg;
    logic [15:0] friction_scale_reg;
    logic [30:0] velocity_limit_reg;
    logic [30:0] fall_limit_reg;
    logic        gravity_enable_reg;
    logic [30:0] gravity_accel_reg;

    logic [4:0]  state_reg;
    q16_t        vx_reg, vy_reg;
    logic        grounded_reg;
    q16_t        fx_reg, fy_reg, px_reg, py_reg, res_x_reg, res_y_reg;
    logic [15:0] dt_reg;
    logic [31:0] md_reg;
    logic [39:0] t_reg;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;
    logic [31:0] num_reg;
    logic [31:0] len_reg;
    logic        phase_reg;
    logic        axis_reg;
    logic [63:0] it_n_reg;
    logic [33:0] rem_reg;
    logic [31:0] q_reg;
    logic [4:0]  cnt_reg;
    logic        out_valid_reg;
    q16_t        out_x_reg, out_y_reg, out_vx_reg, out_vy_reg;

    logic [31:0] mul_a, mul_b;
    logic        cfg_wr;
    logic [35:0] sq_rem2, sq_trial;
    logic        sq_ge;
    logic [32:0] dv_rem2;
    logic        dv_ge;
    logic [63:0] fsum;
    logic [31:0] f_val;
    q16_t        v_sel;
    logic [31:0] v_mag, new_mag;
    q16_t        v_new;
    logic        load_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign item.ready = (state_reg == S_IDLE);

    always_comb
    begin
        case (paddr[4:2])
            REG_MASS:           prdata = {16'd0, mass_reg};
            REG_FRICTION:       prdata = {8'd0, friction_reg};
            REG_FRICTION_SCALE: prdata = {16'd0, friction_scale_reg};
            REG_VELOCITY_LIMIT: prdata = {1'b0, velocity_limit_reg};
            REG_FALL_LIMIT:     prdata = {1'b0, fall_limit_reg};
            REG_GRAVITY_ENABLE: prdata = {31'd0, gravity_enable_reg};
            REG_GRAVITY_ACCEL:  prdata = {1'b0, gravity_accel_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            S_MD:  begin mul_a = {16'd0, mass_reg}; mul_b = {16'd0, dt_reg}; end
            S_FX:  begin mul_a = mag32(fx_reg); mul_b = prod_reg[31:0]; end
            S_FY:  begin mul_a = mag32(fy_reg); mul_b = md_reg; end
            S_FR1: begin mul_a = {16'd0, mass_reg}; mul_b = {16'd0, friction_scale_reg}; end
            S_FR2: begin mul_a = prod_reg[31:0]; mul_b = {8'd0, friction_reg}; end
            S_FR3: begin mul_a = prod_reg[47:16]; mul_b = {16'd0, dt_reg}; end
            S_FR4: begin mul_a = {24'd0, t_reg[39:32]}; mul_b = {16'd0, dt_reg}; end
            S_SQX: begin mul_a = mag32(vx_reg); mul_b = mag32(vx_reg); end
            S_SQY: begin mul_a = mag32(vy_reg); mul_b = mag32(vy_reg); end
            S_SCM: begin mul_a = v_mag; mul_b = num_reg; end
            S_GR1: begin mul_a = {1'b0, gravity_accel_reg}; mul_b = {16'd0, dt_reg}; end
            S_PX:  begin mul_a = mag32(vx_reg); mul_b = {16'd0, dt_reg}; end
            S_PY:  begin mul_a = mag32(vy_reg); mul_b = {16'd0, dt_reg}; end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign sq_rem2  = {rem_reg, it_n_reg[63:62]};
    assign sq_trial = {2'b00, q_reg, 2'b01};
    assign sq_ge    = (sq_rem2 >= sq_trial);
    assign dv_rem2  = {rem_reg[31:0], it_n_reg[31]};
    assign dv_ge    = (dv_rem2 >= {1'b0, len_reg});

    assign fsum  = acc_reg + {prod_reg[31:0], 32'd0};
    assign f_val = (fsum[63:40] != 24'd0) ? 32'hFFFF_FFFF : fsum[39:8];

    assign v_sel   = axis_reg ? vy_reg : vx_reg;
    assign v_mag   = mag32(v_sel);
    assign new_mag = phase_reg ? q_reg : (v_mag - q_reg);
    assign v_new   = v_sel[31] ? q16_t'(32'd0 - new_mag) : q16_t'(new_mag);

    assign load_out = (state_reg == S_FIN) && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg           <= 16'd256;
            friction_reg       <= 24'd102400;
            friction_scale_reg <= 16'd768;
            velocity_limit_reg <= 31'd65536000;
            fall_limit_reg     <= 31'd65536000;
            gravity_enable_reg <= 1'b0;
            gravity_accel_reg  <= 31'd32768000;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_MASS:           mass_reg           <= pwdata[15:0];
                REG_FRICTION:       friction_reg       <= pwdata[23:0];
                REG_FRICTION_SCALE: friction_scale_reg <= pwdata[15:0];
                REG_VELOCITY_LIMIT: velocity_limit_reg <= pwdata[30:0];
                REG_FALL_LIMIT:     fall_limit_reg     <= pwdata[30:0];
                REG_GRAVITY_ENABLE: gravity_enable_reg <= pwdata[0];
                REG_GRAVITY_ACCEL:  gravity_accel_reg  <= pwdata[30:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a * mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vx_reg        <= '0;
            vy_reg        <= '0;
            grounded_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        px_reg    <= item.position_x;
                        py_reg    <= item.position_y;
                        res_x_reg <= item.position_x;
                        res_y_reg <= item.position_y;
                        fx_reg    <= item.force_x;
                        fy_reg    <= item.force_y;
                        dt_reg    <= item.frame_time;
                        if (item.action == ACTION_SET)
                        begin
                            grounded_reg <= item.on_ground;
                            if (item.on_ground && !vy_reg[31] && (vy_reg != '0))
                            begin
                                vy_reg <= '0;
                            end
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_MD;
                        end
                    end
                end
                S_MD: state_reg <= S_FX;
                S_FX:
                begin
                    md_reg    <= prod_reg[31:0];
                    state_reg <= S_FY;
                end
                S_FY:
                begin
                    vx_reg    <= sat_add(vx_reg, fx_reg[31], prod_reg[63:24]);
                    state_reg <= S_FSEL;
                end
                S_FSEL:
                begin
                    vy_reg <= sat_add(vy_reg, fy_reg[31], prod_reg[63:24]);
                    if (!gravity_enable_reg || grounded_reg)
                    begin
                        state_reg <= S_FR1;
                    end
                    else
                    begin
                        state_reg <= S_GR1;
                    end
                end
                S_FR1: state_reg <= S_FR2;
                S_FR2: state_reg <= S_FR3;
                S_FR3:
                begin
                    t_reg     <= prod_reg[55:16];
                    state_reg <= S_FR4;
                end
                S_FR4:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_FR5;
                end
                S_FR5:
                begin
                    num_reg   <= f_val;
                    phase_reg <= 1'b0;
                    if ((vx_reg == '0) && (vy_reg == '0))
                    begin
                        state_reg <= S_LIM;
                    end
                    else
                    begin
                        state_reg <= S_SQX;
                    end
                end
                S_SQX: state_reg <= S_SQY;
                S_SQY:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_SQS;
                end
                S_SQS:
                begin
                    it_n_reg  <= acc_reg + prod_reg;
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    rem_reg  <= sq_ge ? 34'(sq_rem2 - sq_trial) : sq_rem2[33:0];
                    q_reg    <= {q_reg[30:0], sq_ge};
                    it_n_reg <= {it_n_reg[61:0], 2'b00};
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= S_LEN;
                    end
                end
                S_LEN:
                begin
                    len_reg  <= q_reg;
                    axis_reg <= 1'b0;
                    if (!phase_reg)
                    begin
                        if (q_reg < num_reg)
                        begin
                            vx_reg    <= '0;
                            vy_reg    <= '0;
                            state_reg <= S_LIM;
                        end
                        else
                        begin
                            state_reg <= S_SCM;
                        end
                    end
                    else if ({1'b0, velocity_limit_reg} < q_reg)
                    begin
                        num_reg   <= {1'b0, velocity_limit_reg};
                        state_reg <= S_SCM;
                    end
                    else
                    begin
                        state_reg <= S_PX;
                    end
                end
                S_SCM: state_reg <= S_SCD;
                S_SCD:
                begin
                    it_n_reg  <= prod_reg;
                    rem_reg   <= {2'b00, prod_reg[63:32]};
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= {2'b00, (dv_ge ? 32'(dv_rem2 - {1'b0, len_reg}) : dv_rem2[31:0])};
                    q_reg    <= {q_reg[30:0], dv_ge};
                    it_n_reg <= {it_n_reg[62:0], 1'b0};
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= S_SCW;
                    end
                end
                S_SCW:
                begin
                    if (!axis_reg)
                    begin
                        vx_reg    <= v_new;
                        axis_reg  <= 1'b1;
                        state_reg <= S_SCM;
                    end
                    else
                    begin
                        vy_reg    <= v_new;
                        state_reg <= phase_reg ? S_PX : S_LIM;
                    end
                end
                S_GR1: state_reg <= S_GR2;
                S_GR2:
                begin
                    vy_reg    <= sat_add(vy_reg, 1'b0, prod_reg[55:16]);
                    state_reg <= S_LIM;
                end
                S_LIM:
                begin
                    if (gravity_enable_reg)
                    begin
                        if (mag32(vx_reg) > {1'b0, velocity_limit_reg})
                        begin
                            vx_reg <= vx_reg[31] ? q16_t'(32'd0 - {1'b0, velocity_limit_reg})
                                                 : q16_t'({1'b0, velocity_limit_reg});
                        end
                        if (mag32(vy_reg) > {1'b0, fall_limit_reg})
                        begin
                            vy_reg <= vy_reg[31] ? q16_t'(32'd0 - {1'b0, fall_limit_reg})
                                                 : q16_t'({1'b0, fall_limit_reg});
                        end
                        state_reg <= S_PX;
                    end
                    else
                    begin
                        phase_reg <= 1'b1;
                        state_reg <= S_SQX;
                    end
                end
                S_PX: state_reg <= S_PY;
                S_PY:
                begin
                    res_x_reg <= sat_add(px_reg, vx_reg[31], {8'd0, prod_reg[47:16]});
                    state_reg <= S_PD;
                end
                S_PD:
                begin
                    res_y_reg <= sat_add(py_reg, vy_reg[31], {8'd0, prod_reg[47:16]});
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_x_reg  <= res_x_reg;
            out_y_reg  <= res_y_reg;
            out_vx_reg <= vx_reg;
            out_vy_reg <= vy_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.new_x      = out_x_reg;
    assign result.new_y      = out_y_reg;
    assign result.velocity_x = out_vx_reg;
    assign result.velocity_y = out_vy_reg;

endmodule

[sv/rbvs_checker.sv]
module rbvs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_vx,
    input logic        pready
);
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready after accepted transaction");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_vx))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind rigid_body_velocity_step_top rbvs_checker u_rbvs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_vx    (result.velocity_x),
    .pready    (pready)
);

[dv/tb_top.sv]
module tb_top;
    import rbvs_pkg::*;

    typedef struct {
        logic action;
        q16_t force_x;
        q16_t force_y;
        logic [15:0] frame_time;
        q16_t position_x;
        q16_t position_y;
        logic on_ground;
    } body_item_t;

    typedef struct {
        q16_t new_x;
        q16_t new_y;
        q16_t velocity_x;
        q16_t velocity_y;
    } motion_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    rbvs_in_if  in_if ();
    rbvs_out_if out_if ();

    rigid_body_velocity_step_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (in_if.sink),
        .result  (out_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [63:0] cfg_mass;
    logic [63:0] cfg_friction;
    logic [63:0] cfg_fscale;
    logic [63:0] cfg_vlimit;
    logic [63:0] cfg_flimit;
    logic [63:0] cfg_gravity_on;
    logic [63:0] cfg_gaccel;
    longint      body_vx;
    longint      body_vy;
    logic        body_grounded;

    motion_t expected_motion[$];
    int errors = 0;
    int burst_left = 0;
    int stall_hold = 0;
    int idle_cycles = 0;
    int rx_phase = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint shift_tz(input longint v, input int n);
        return (v < 0) ? -((-v) >>> n) : (v >>> n);
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] vector_length(input longint x, input longint y);
        logic [63:0] n;
        logic [63:0] root;
        logic [63:0] bit_v;
        n = magnitude(x) * magnitude(x) + magnitude(y) * magnitude(y);
        root = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n)
        begin
            bit_v = bit_v >> 2;
        end
        while (bit_v != 0)
        begin
            if (n >= root + bit_v)
            begin
                n = n - (root + bit_v);
                root = (root >> 1) + bit_v;
            end
            else
            begin
                root = root >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return root;
    endfunction

    function automatic longint scale_tz(input longint v, input logic [63:0] num,
                                        input logic [63:0] den);
        logic [63:0] m;
        m = (magnitude(v) * num) / den;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp_axis(input longint v, input logic [63:0] lim);
        if (magnitude(v) > lim)
        begin
            return (v < 0) ? -longint'(lim) : longint'(lim);
        end
        return v;
    endfunction

    function automatic motion_t advance_body(input body_item_t it);
        motion_t r;
        longint px;
        longint py;
        longint dt;
        logic [63:0] fric;
        logic [63:0] len;
        logic grav;
        px = longint'(it.position_x);
        py = longint'(it.position_y);
        dt = longint'({48'd0, it.frame_time});
        grav = cfg_gravity_on != 0;
        r.new_x = it.position_x;
        r.new_y = it.position_y;
        if (it.action == ACTION_SET)
        begin
            body_grounded = it.on_ground;
            if (body_grounded && body_vy > 0)
            begin
                body_vy = 0;
            end
        end
        else
        begin
            body_vx = sat32(body_vx +
                            shift_tz(longint'(it.force_x) * longint'(cfg_mass) * dt, 24));
            body_vy = sat32(body_vy +
                            shift_tz(longint'(it.force_y) * longint'(cfg_mass) * dt, 24));
            if (!grav || body_grounded)
            begin
                fric = (((cfg_friction * cfg_fscale * cfg_mass) >> 16) * 64'(dt)) >> 8;
                if (fric > 64'hFFFF_FFFF)
                begin
                    fric = 64'hFFFF_FFFF;
                end
                if (body_vx != 0 || body_vy != 0)
                begin
                    len = vector_length(body_vx, body_vy);
                    if (len < fric)
                    begin
                        body_vx = 0;
                        body_vy = 0;
                    end
                    else
                    begin
                        body_vx = body_vx - scale_tz(body_vx, fric, len);
                        body_vy = body_vy - scale_tz(body_vy, fric, len);
                    end
                end
            end
            if (grav && !body_grounded)
            begin
                body_vy = sat32(body_vy + longint'((cfg_gaccel * 64'(dt)) >> 16));
            end
            if (grav)
            begin
                body_vx = clamp_axis(body_vx, cfg_vlimit);
                body_vy = clamp_axis(body_vy, cfg_flimit);
            end
            else
            begin
                len = vector_length(body_vx, body_vy);
                if (cfg_vlimit < len)
                begin
                    body_vx = scale_tz(body_vx, cfg_vlimit, len);
                    body_vy = scale_tz(body_vy, cfg_vlimit, len);
                end
            end
            r.new_x = q16_t'(sat32(px + shift_tz(body_vx * dt, 16)));
            r.new_y = q16_t'(sat32(py + shift_tz(body_vy * dt, 16)));
        end
        r.velocity_x = q16_t'(body_vx);
        r.velocity_y = q16_t'(body_vy);
        return r;
    endfunction

    function automatic body_item_t make_tick(input q16_t fx, input q16_t fy,
                                             input logic [15:0] dt, input q16_t px,
                                             input q16_t py);
        body_item_t it;
        it.action = ACTION_TICK;
        it.force_x = fx;
        it.force_y = fy;
        it.frame_time = dt;
        it.position_x = px;
        it.position_y = py;
        it.on_ground = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic body_item_t make_set(input logic g);
        body_item_t it;
        it.action = ACTION_SET;
        it.force_x = $urandom;
        it.force_y = $urandom;
        it.frame_time = 16'($urandom);
        it.position_x = $urandom;
        it.position_y = $urandom;
        it.on_ground = g;
        return it;
    endfunction

    function automatic q16_t pick_q16();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h8000_0000;
            3: v = 32'd0;
            default:
            begin
                v = $urandom_range(0, 32'h0400_0000);
                if ($urandom_range(0, 1))
                begin
                    v = -v;
                end
            end
        endcase
        return q16_t'(v);
    endfunction

    function automatic logic [15:0] pick_dt();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 2048));
        endcase
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_MASS:           cfg_mass = value & 32'hFFFF;
            REG_FRICTION:       cfg_friction = value & 32'hFF_FFFF;
            REG_FRICTION_SCALE: cfg_fscale = value & 32'hFFFF;
            REG_VELOCITY_LIMIT: cfg_vlimit = value & 32'h7FFF_FFFF;
            REG_FALL_LIMIT:     cfg_flimit = value & 32'h7FFF_FFFF;
            REG_GRAVITY_ENABLE: cfg_gravity_on = value & 32'h1;
            REG_GRAVITY_ACCEL:  cfg_gaccel = value & 32'h7FFF_FFFF;
            default: ;
        endcase
    endtask

    task automatic send_item(input body_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                @(negedge clk);
                in_if.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        @(negedge clk);
        in_if.action = it.action;
        in_if.force_x = it.force_x;
        in_if.force_y = it.force_y;
        in_if.frame_time = it.frame_time;
        in_if.position_x = it.position_x;
        in_if.position_y = it.position_y;
        in_if.on_ground = it.on_ground;
        in_if.valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_if.ready);
        expected_motion.push_back(advance_body(it));
        burst_left--;
    endtask

    task automatic settle();
        @(negedge clk);
        in_if.valid = 1'b0;
        burst_left = 0;
        while (expected_motion.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (150) @(posedge clk);
    endtask

    task automatic random_config();
        cfg_write(REG_MASS, ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1024));
        cfg_write(REG_FRICTION, ($urandom_range(0, 3) == 0) ? $urandom
                                                             : $urandom_range(0, 200000));
        cfg_write(REG_FRICTION_SCALE, ($urandom_range(0, 3) == 0) ? $urandom
                                                                   : $urandom_range(0, 1024));
        cfg_write(REG_VELOCITY_LIMIT, ($urandom_range(0, 3) == 0) ? $urandom
                                                                   : $urandom_range(0, 1 << 27));
        cfg_write(REG_FALL_LIMIT, ($urandom_range(0, 3) == 0) ? $urandom
                                                               : $urandom_range(0, 1 << 27));
        cfg_write(REG_GRAVITY_ENABLE, $urandom);
        cfg_write(REG_GRAVITY_ACCEL, ($urandom_range(0, 3) == 0) ? $urandom
                                                                  : $urandom_range(0, 1 << 26));
    endtask

    task automatic test_directed();
        send_item(make_tick(0, 0, 0, 0, 0));
        send_item(make_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF,
                            32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_item(make_tick(32'sh8000_0000, 32'sh8000_0000, 16'hFFFF,
                            32'sh8000_0000, 32'sh8000_0000));
        send_item(make_tick(32'sh0001_0000, -32'sh0001_0000, 16'd655, 0, 0));
        send_item(make_tick(32'sh0300_0000, 32'sh0200_0000, 16'd6553, 100, -100));
        send_item(make_set(1'b1));
        send_item(make_set(1'b0));
        settle();
        cfg_write(REG_GRAVITY_ENABLE, 1);
        send_item(make_tick(0, 32'sh0100_0000, 16'd6553, 0, 0));
        send_item(make_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF, 0, 0));
        send_item(make_tick(32'sh8000_0000, 32'sh8000_0000, 16'hFFFF, 0, 0));
        send_item(make_set(1'b1));
        send_item(make_tick(32'sh0010_0000, -32'sh0010_0000, 16'd1000, 5, 5));
        send_item(make_tick(0, 32'sh0400_0000, 16'd4000, 0, 0));
        send_item(make_set(1'b1));
        send_item(make_set(1'b0));
        settle();
        cfg_write(REG_MASS, 16'hFFFF);
        cfg_write(REG_FRICTION, 24'hFF_FFFF);
        cfg_write(REG_FRICTION_SCALE, 16'hFFFF);
        cfg_write(REG_VELOCITY_LIMIT, 32'h7FFF_FFFF);
        cfg_write(REG_FALL_LIMIT, 32'h7FFF_FFFF);
        cfg_write(REG_GRAVITY_ACCEL, 32'h7FFF_FFFF);
        cfg_write(REG_GRAVITY_ENABLE, 0);
        send_item(make_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 0, 0));
        send_item(make_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'd1, 0, 0));
        settle();
        cfg_write(REG_GRAVITY_ENABLE, 1);
        send_item(make_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF, 0, 0));
        send_item(make_tick(0, 0, 16'hFFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        settle();
        cfg_write(REG_MASS, 0);
        cfg_write(REG_FRICTION, 0);
        cfg_write(REG_FRICTION_SCALE, 0);
        cfg_write(REG_VELOCITY_LIMIT, 0);
        cfg_write(REG_FALL_LIMIT, 0);
        cfg_write(REG_GRAVITY_ACCEL, 0);
        send_item(make_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF, 1, 1));
        settle();
        cfg_write(REG_GRAVITY_ENABLE, 0);
        send_item(make_tick(32'sh8000_0000, 32'sh8000_0000, 16'hFFFF, 1, 1));
        settle();
    endtask

    task automatic test_random();
        body_item_t it;
        for (int phase = 0; phase < 10; phase++)
        begin
            random_config();
            for (int k = 0; k < 95; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    it = make_set(1'($urandom_range(0, 1)));
                end
                else
                begin
                    it = make_tick(pick_q16(), pick_q16(), pick_dt(), pick_q16(), pick_q16());
                end
                send_item(it);
            end
            settle();
        end
    endtask

    task automatic test_backpressure();
        stall_hold = 500;
        for (int k = 0; k < 30; k++)
        begin
            send_item(make_tick(pick_q16(), pick_q16(), pick_dt(), pick_q16(), pick_q16()));
        end
        settle();
    endtask

    task automatic test_drain_pause();
        for (int k = 0; k < 20; k++)
        begin
            send_item(make_tick(pick_q16(), pick_q16(), pick_dt(), pick_q16(), pick_q16()));
            if (k == 9)
            begin
                settle();
            end
        end
        settle();
    endtask

    always @(negedge clk)
    begin
        rx_phase <= rx_phase + 1;
        if (stall_hold > 0)
        begin
            out_if.ready <= 1'b0;
            stall_hold <= stall_hold - 1;
        end
        else if ((rx_phase % 160) < 60)
        begin
            out_if.ready <= 1'b1;
        end
        else
        begin
            out_if.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge clk)
    begin
        motion_t exp_m;
        if (out_if.valid && out_if.ready)
        begin
            if (expected_motion.size() == 0)
            begin
                $display("%0t unexpected result x=%h y=%h vx=%h vy=%h", $time,
                         out_if.new_x, out_if.new_y, out_if.velocity_x, out_if.velocity_y);
                errors++;
            end
            else
            begin
                exp_m = expected_motion.pop_front();
                if (out_if.new_x !== exp_m.new_x)
                begin
                    $display("%0t new_x exp %h got %h", $time, exp_m.new_x, out_if.new_x);
                    errors++;
                end
                if (out_if.new_y !== exp_m.new_y)
                begin
                    $display("%0t new_y exp %h got %h", $time, exp_m.new_y, out_if.new_y);
                    errors++;
                end
                if (out_if.velocity_x !== exp_m.velocity_x)
                begin
                    $display("%0t velocity_x exp %h got %h", $time, exp_m.velocity_x,
                             out_if.velocity_x);
                    errors++;
                end
                if (out_if.velocity_y !== exp_m.velocity_y)
                begin
                    $display("%0t velocity_y exp %h got %h", $time, exp_m.velocity_y,
                             out_if.velocity_y);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= 20000)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.action = ACTION_TICK;
        in_if.force_x = '0;
        in_if.force_y = '0;
        in_if.frame_time = '0;
        in_if.position_x = '0;
        in_if.position_y = '0;
        in_if.on_ground = 1'b0;
        out_if.ready = 1'b0;
        cfg_mass = 256;
        cfg_friction = 102400;
        cfg_fscale = 768;
        cfg_vlimit = 65536000;
        cfg_flimit = 65536000;
        cfg_gravity_on = 0;
        cfg_gaccel = 32768000;
        body_vx = 0;
        body_vy = 0;
        body_grounded = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random();
        test_backpressure();
        test_drain_pause();
        settle();
        if (errors == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule

[rigid_body_velocity_step_top.f]
sv/rbvs_pkg.sv
sv/rbvs_if.sv
sv/rigid_body_velocity_step_top.sv
sv/rbvs_checker.sv
dv/tb_top.sv
